/* design/sdlj_pkg.sv */
// Shared types and constants for the signed decimal left-justify formatter.
package sdlj_pkg;

   localparam int MAG_W    = 32;
   localparam int FIELD_W  = 6;
   localparam int DIGIT_W  = 4;
   localparam int NDIG_W   = 4;
   localparam int MAX_DIGS = 10;
   localparam int DIGS_W   = MAX_DIGS * DIGIT_W;

   // Reciprocal of ten scaled by 2^35; exact floor quotient for any 32-bit value.
   localparam logic [MAG_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int               RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // One converted item, handed from the front part to the back part.
   typedef struct packed {
      logic                neg;
      logic [FIELD_W-1:0]  zeros;
      logic [NDIG_W-1:0]   ndig;
      logic [DIGS_W-1:0]   digits;
      logic [FIELD_W-1:0]  total;
   } job_type;

endpackage

/* design/signed_decimal_left_justify_format.sv */
// Top level of the signed decimal left-justify formatter (printf "%-W.Pd").
// An item is taken when start is high and busy is low; its text comes out one ASCII
// character per cycle on rsp_char_out with rsp_strobe high, the final one flagged by
// rsp_last, and the receiver must take each character in the cycle it appears. A zero
// with precision and width both zero produces no characters. The front part does one
// divide-by-ten per cycle, taking one decimal digit of the magnitude (up to ten) each
// time, then hands the item over once the queue has room, and holds busy meanwhile. A
// two-entry queue lets it convert the next item while the back part is still printing.
// The back part loads an item from the queue, then prints its text, which is at most
// MAX_FIELD characters. When the back part is idle, a handed-over item passes through
// the queue entry and the back part's item registers before its first character
// leaves the registered output.
module signed_decimal_left_justify_format #(
   parameter int MAX_FIELD = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_precision,
   input  logic [5:0]         req_width,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_char_out,
   output logic               rsp_last
);
   import sdlj_pkg::*;

   job_type   push_job;
   job_type   pop_job;
   logic      push;
   logic      pop;
   logic      q_full;
   logic      q_empty;

   sdlj_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_precision (req_precision),
      .req_width     (req_width),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job)
   );

   sdlj_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   sdlj_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .job          (pop_job),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

/* design/sdlj_front.sv */
// Front part: accepts an item, splits the magnitude into decimal digits and sizes the text.
module sdlj_front #(
   parameter int MAX_FIELD = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   input  logic [5:0]                    req_precision,
   input  logic [5:0]                    req_width,
   input  logic                          q_full,
   output logic                          push,
   output sdlj_pkg::job_type             push_job
);
   import sdlj_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_CONV = 1'b1;

   localparam logic [FIELD_W-1:0] PREC_MAX = FIELD_W'(MAX_FIELD - 1);
   localparam logic [FIELD_W-1:0] WID_MAX  = FIELD_W'(MAX_FIELD);

   logic                 state_ff, state_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [FIELD_W-1:0]   prec_ff, prec_in;
   logic [FIELD_W-1:0]   wid_ff, wid_in;
   logic [DIGS_W-1:0]    digits_ff, digits_in;
   logic [NDIG_W-1:0]    ndig_ff, ndig_in;

   logic [2*MAG_W-1:0]   prod;
   logic [MAG_W-1:0]     quot;
   logic [MAG_W-1:0]     rem;
   logic [FIELD_W-1:0]   ndig_ext;
   logic [FIELD_W-1:0]   digit_span;
   logic [FIELD_W-1:0]   body;
   logic [FIELD_W-1:0]   total;
   logic                 accept;
   logic                 done;

   // Divide by ten through the scaled reciprocal, remainder by multiply-back.
   assign prod = {{MAG_W{1'b0}}, mag_ff} * {{MAG_W{1'b0}}, RECIP_TEN};
   assign quot = MAG_W'(prod[2*MAG_W-1:RECIP_SHIFT]);
   assign rem  = mag_ff - ((quot << 3) + (quot << 1));

   // Text length: sign, digits padded to the precision, then the width, capped at WID_MAX.
   always_comb begin
      ndig_ext   = FIELD_W'(ndig_ff);
      digit_span = (prec_ff > ndig_ext) ? prec_ff : ndig_ext;
      body       = FIELD_W'(neg_ff) + digit_span;
      total      = (body > wid_ff) ? body : wid_ff;
      if (total > WID_MAX) begin
         total = WID_MAX;
      end
   end

   assign busy   = (state_ff != STATE_IDLE);
   assign accept = start && !busy;
   assign done   = (state_ff == STATE_CONV) && (mag_ff == '0) && !q_full;
   assign push   = done && (total != '0);

   always_comb begin
      push_job.neg    = neg_ff;
      push_job.zeros  = (prec_ff > ndig_ext) ? (prec_ff - ndig_ext) : '0;
      push_job.ndig   = ndig_ff;
      push_job.digits = digits_ff;
      push_job.total  = total;
   end

   // Sequencer: load on accept, one digit per cycle, hand over once the magnitude is spent and the queue has room.
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      prec_in   = prec_ff;
      wid_in    = wid_ff;
      digits_in = digits_ff;
      ndig_in   = ndig_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               neg_in    = req_value[31];
               mag_in    = req_value[31] ? (MAG_W'(0) - MAG_W'(req_value)) : MAG_W'(req_value);
               prec_in   = (req_precision > PREC_MAX) ? PREC_MAX : req_precision;
               wid_in    = (req_width > WID_MAX) ? WID_MAX : req_width;
               digits_in = '0;
               ndig_in   = '0;
               state_in  = STATE_CONV;
            end
         end
         STATE_CONV: begin
            if (mag_ff != '0) begin
               // Newest digit enters at the top, so the leading digit ends up highest.
               digits_in = {rem[DIGIT_W-1:0], digits_ff[DIGS_W-1:DIGIT_W]};
               mag_in    = quot;
               ndig_in   = ndig_ff + NDIG_W'(1);
            end else if (done) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      prec_ff   <= prec_in;
      wid_ff    <= wid_in;
      digits_ff <= digits_in;
      ndig_ff   <= ndig_in;
   end

endmodule

/* design/sdlj_queue.sv */
// Two-entry item queue between the front and back parts.
module sdlj_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sdlj_pkg::job_type   push_job,
   input  logic                pop,
   output sdlj_pkg::job_type   pop_job,
   output logic                full,
   output logic                empty
);
   import sdlj_pkg::*;

   job_type      mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/sdlj_back.sv */
// Back part: takes a converted item and emits its text one character per cycle.
module sdlj_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  sdlj_pkg::job_type   job,
   output logic                pop,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last
);
   import sdlj_pkg::*;

   logic                 active_ff, active_in;
   logic                 sign_ff, sign_in;
   logic [FIELD_W-1:0]   zeros_ff, zeros_in;
   logic [NDIG_W-1:0]    ndig_ff, ndig_in;
   logic [DIGS_W-1:0]    digits_ff, digits_in;
   logic [FIELD_W-1:0]   remain_ff, remain_in;
   logic                 strobe_ff, strobe_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;

   assign pop = !active_ff && !q_empty;

   // Pick the next character: sign, leading zeros, digits, then spaces.
   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      zeros_in  = zeros_ff;
      ndig_in   = ndig_ff;
      digits_in = digits_ff;
      remain_in = remain_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      if (pop) begin
         active_in = 1'b1;
         sign_in   = job.neg;
         zeros_in  = job.zeros;
         ndig_in   = job.ndig;
         digits_in = job.digits;
         remain_in = job.total;
      end else if (active_ff) begin
         strobe_in = 1'b1;
         last_in   = (remain_ff == FIELD_W'(1));
         remain_in = remain_ff - FIELD_W'(1);
         if (last_in) begin
            active_in = 1'b0;
         end
         if (sign_ff) begin
            char_in = CHAR_MINUS;
            sign_in = 1'b0;
         end else if (zeros_ff != '0) begin
            char_in  = CHAR_ZERO;
            zeros_in = zeros_ff - FIELD_W'(1);
         end else if (ndig_ff != '0) begin
            char_in   = CHAR_ZERO + 8'(digits_ff[DIGS_W-1 -: DIGIT_W]);
            digits_in = digits_ff << DIGIT_W;
            ndig_in   = ndig_ff - NDIG_W'(1);
         end else begin
            char_in = CHAR_SPACE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
      sign_ff   <= sign_in;
      zeros_ff  <= zeros_in;
      ndig_ff   <= ndig_in;
      digits_ff <= digits_in;
      remain_ff <= remain_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule
